/* sv/mtb_pkg.sv */
// ----------------------------------------------------------------------------
// mtb_pkg - shared types and codes of the multi token bucket limiter
// Request and response payload layouts, bucket entry layout, operation and
// status codes, and the default table size.
// ----------------------------------------------------------------------------
package mtb_pkg;

   // default number of buckets in the table
   localparam int NUM_BUCKETS_DEF = 16;

   // request codes
   localparam logic [2:0] REQ_TICK     = 3'd0;
   localparam logic [2:0] REQ_ALLOCATE = 3'd1;
   localparam logic [2:0] REQ_FETCH    = 3'd2;
   localparam logic [2:0] REQ_RETURN   = 3'd3;
   localparam logic [2:0] REQ_RELEASE  = 3'd4;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_SLOT = 2'd1;
   localparam logic [1:0] ST_BAD_ID  = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  bucket_id;
      logic [15:0] amount;
      logic [15:0] fill_rate;
      logic [15:0] burst_limit;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot_index;
      logic [15:0] granted;
   } rsp_payload_type;

   // one table entry as stored in the bucket RAM
   typedef struct packed {
      logic        live;
      logic [15:0] rate;
      logic [15:0] cap;
      logic [15:0] level;
   } entry_type;

endpackage

/* sv/mtb_ram.sv */
// ----------------------------------------------------------------------------
// mtb_ram - generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/multi_token_bucket_limiter_unit.sv */
// ----------------------------------------------------------------------------
// multi_token_bucket_limiter_unit - table of token buckets
// Fetch, return and release: one read-modify-write of the addressed bucket.
// Allocate scans from slot 0 and takes the first free slot, or reports no slot
// after the last; tick updates every live bucket. The result waits in a hold
// register until the output register is free; then the next request is taken.
// Reset: synchronous; a clearing pass frees every slot.
// ----------------------------------------------------------------------------
module multi_token_bucket_limiter_unit #(
   parameter int NUM_BUCKETS = mtb_pkg::NUM_BUCKETS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mtb_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output mtb_pkg::rsp_payload_type rsp_payload
);

   localparam int ADDR_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int IDX_W  = ADDR_W + 4;
   localparam int ENT_W  = $bits(mtb_pkg::entry_type);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BUCKETS - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         scan_ff, scan_in;
   mtb_pkg::req_payload_type  req_ff, req_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   mtb_pkg::rsp_payload_type  rsp_ff, rsp_in;
   mtb_pkg::rsp_payload_type  hold_ff, hold_in;

   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   mtb_pkg::entry_type        wr_ent;
   logic [ADDR_W-1:0]         rd_addr;
   logic [ENT_W-1:0]          rd_data;
   mtb_pkg::entry_type        ent;

   logic                      done;
   mtb_pkg::rsp_payload_type  res;

   logic                      sub_mode;
   logic [16:0]               op_a, op_b, sum;
   logic                      over_cap;
   logic [15:0]               clamped;
   logic                      id_ok;
   logic                      last;
   logic [ADDR_W-1:0]         scan_next;
   logic [IDX_W-1:0]          slot_wide;

   // bucket id to RAM address, zero-extended or truncated to the table size
   function automatic logic [ADDR_W-1:0] id_to_addr(input logic [3:0] id);
      logic [IDX_W-1:0] wide;
      wide = IDX_W'(id);
      return wide[ADDR_W-1:0];
   endfunction

   mtb_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_BUCKETS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ent       = mtb_pkg::entry_type'(rd_data);
   assign last      = (scan_ff == LAST_ADDR);
   assign scan_next = last ? '0 : scan_ff + 1'b1;
   assign slot_wide = IDX_W'(scan_ff);
   assign id_ok     = (32'(req_ff.bucket_id) < NUM_BUCKETS) && ent.live;

   // shared add/subtract unit with clamp against the burst cap
   always_comb begin
      sub_mode = (req_ff.req_type == mtb_pkg::REQ_FETCH);
      op_a     = {1'b0, ent.level};
      if (req_ff.req_type == mtb_pkg::REQ_TICK) begin
         op_b = {1'b0, ent.rate};
      end else begin
         op_b = {1'b0, req_ff.amount};
      end
      sum      = op_a + (sub_mode ? ~op_b : op_b) + 17'(sub_mode);
      over_cap = (sum > {1'b0, ent.cap});
      clamped  = over_cap ? ent.cap : sum[15:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      req_in       = req_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = scan_ff;
      wr_ent       = ent;
      rd_addr      = scan_next;
      req_ready    = 1'b0;
      done         = 1'b0;
      res          = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_ent  = '0;
            scan_in = scan_next;
            if (last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_payload.req_type inside {mtb_pkg::REQ_TICK, mtb_pkg::REQ_ALLOCATE}) begin
               rd_addr = '0;
            end else begin
               rd_addr = id_to_addr(req_payload.bucket_id);
            end
            if (req_valid) begin
               req_in  = req_payload;
               scan_in = '0;
               if (req_payload.req_type inside
                   {mtb_pkg::REQ_TICK, mtb_pkg::REQ_ALLOCATE}) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            // single-entry read-modify-write on the addressed bucket
            done    = 1'b1;
            wr_addr = id_to_addr(req_ff.bucket_id);
            case (req_ff.req_type)
               mtb_pkg::REQ_FETCH: begin
                  if (!id_ok) begin
                     res.status = mtb_pkg::ST_BAD_ID;
                  end else if (ent.level == '0) begin
                     res.status = mtb_pkg::ST_EMPTY;
                  end else begin
                     wr_en = 1'b1;
                     if (sum[16]) begin
                        res.granted  = ent.level;
                        wr_ent.level = '0;
                     end else begin
                        res.granted  = req_ff.amount;
                        wr_ent.level = sum[15:0];
                     end
                  end
               end
               mtb_pkg::REQ_RETURN: begin
                  if (!id_ok) begin
                     res.status = mtb_pkg::ST_BAD_ID;
                  end else begin
                     wr_en        = 1'b1;
                     wr_ent.level = clamped;
                  end
               end
               mtb_pkg::REQ_RELEASE: begin
                  if (!id_ok) begin
                     res.status = mtb_pkg::ST_BAD_ID;
                  end else begin
                     wr_en       = 1'b1;
                     wr_ent.live = 1'b0;
                  end
               end
               default: begin
                  res.status = mtb_pkg::ST_OK;
               end
            endcase
         end
         ST_SCAN: begin
            // one bucket per cycle; the next entry is read meanwhile
            scan_in = scan_next;
            if (req_ff.req_type == mtb_pkg::REQ_TICK) begin
               if (ent.live) begin
                  wr_en        = 1'b1;
                  wr_ent.level = clamped;
               end
               done = last;
            end else begin
               if (!ent.live) begin
                  wr_en          = 1'b1;
                  wr_ent.live    = 1'b1;
                  wr_ent.rate    = req_ff.fill_rate;
                  wr_ent.cap     = req_ff.burst_limit;
                  wr_ent.level   = '0;
                  done           = 1'b1;
                  res.slot_index = slot_wide[3:0];
               end else if (last) begin
                  done       = 1'b1;
                  res.status = mtb_pkg::ST_NO_SLOT;
               end
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // deliver the result, or park it until the output register frees up
      if (done) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            hold_in  = res;
            state_in = ST_HOLD;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* sv/mtb_checker.sv */
// ----------------------------------------------------------------------------
// mtb_checker - port-level checks of the token bucket limiter
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module mtb_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input mtb_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input mtb_pkg::rsp_payload_type rsp_payload
);

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // one request in flight: ready drops after each request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   // an error response carries zero granted tokens and a zero slot index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != mtb_pkg::ST_OK |->
         rsp_payload.granted == '0 && rsp_payload.slot_index == '0)
      else $error("nonzero fields on an error response");

   // reset starts the clearing pass with both channels quiet
   assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("channels active right after reset");

endmodule

bind multi_token_bucket_limiter_unit mtb_checker u_mtb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
